### src/mrfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared types, constants and the CRC-16 byte update for the frame checker.
// ----------------------------------------------------------------------------
package mrfc_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [15:0] CRC_PRESET      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  LAST_LEGAL_FUNC = 8'h11;
    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = LEN_W'(4);
    localparam logic [LEN_W-1:0] MAX_LEN         = LEN_W'(MAX_FRAME_BYTES);

    localparam logic [7:0] SLAVE_ADDR_RESET = 8'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_BAD_ADDR  = 3'd1,
        VERDICT_BAD_FUNC  = 3'd2,
        VERDICT_SHORT     = 3'd3,
        VERDICT_BAD_CRC   = 3'd4
    } t_verdict;

    // Summary of one finished frame, handed from front to back.
    typedef struct packed {
        logic [7:0]       addr;
        logic [7:0]       func;
        logic [LEN_W-1:0] len;
        logic             crc_ok;
    } t_frame_sum;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### src/mrfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_front
// Accumulates CRC, length, address and function over a frame; emits a
// summary word on the last byte.
// ----------------------------------------------------------------------------
module mrfc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_end_of_frame,
    output logic                 o_sum_push,
    output mrfc_pkg::t_frame_sum o_sum
);
    import mrfc_pkg::*;

    logic [15:0]      r_crc,  n_crc;
    logic [LEN_W-1:0] r_cnt,  n_cnt;
    logic [7:0]       r_addr, n_addr;
    logic [7:0]       r_func, n_func;

    always_comb begin
        n_addr = (r_cnt == '0) ? i_rx_byte : r_addr;
        n_func = (r_cnt == LEN_W'(1)) ? i_rx_byte : r_func;
        n_crc  = crc_byte(r_crc, i_rx_byte);
        n_cnt  = (r_cnt < MAX_LEN) ? r_cnt + LEN_W'(1) : r_cnt;
    end

    assign o_sum_push   = i_accept & i_end_of_frame;
    assign o_sum.addr   = n_addr;
    // function code counts as zero on a single-byte frame
    assign o_sum.func   = (n_cnt >= LEN_W'(2)) ? n_func : 8'h00;
    assign o_sum.len    = n_cnt;
    assign o_sum.crc_ok = (n_crc == 16'h0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_PRESET;
            r_cnt  <= '0;
            r_addr <= '0;
            r_func <= '0;
        end else if (i_accept) begin
            if (i_end_of_frame) begin
                r_crc  <= CRC_PRESET;
                r_cnt  <= '0;
                r_addr <= '0;
                r_func <= '0;
            end else begin
                r_crc  <= n_crc;
                r_cnt  <= n_cnt;
                r_addr <= n_addr;
                r_func <= n_func;
            end
        end
    end

endmodule

### src/mrfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_queue
// Short FIFO of frame summaries between front and back.
// ----------------------------------------------------------------------------
module mrfc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mrfc_pkg::t_frame_sum i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output mrfc_pkg::t_frame_sum o_data
);
    import mrfc_pkg::*;

    t_frame_sum        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### src/mrfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_back
// Holds the slave address, grades each frame summary and keeps the
// verdict in an output register.
// ----------------------------------------------------------------------------
module mrfc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [7:0]             i_cfg_wr_data,
    input  logic                   i_sum_valid,
    input  mrfc_pkg::t_frame_sum   i_sum,
    output logic                   o_sum_take,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [2:0]             o_verdict,
    output logic [7:0]             o_function_code,
    output logic [mrfc_pkg::LEN_W-1:0] o_frame_length
);
    import mrfc_pkg::*;

    logic [7:0]       r_slave_addr;
    logic             r_valid;
    t_verdict         r_verdict, n_verdict;
    logic [7:0]       r_func;
    logic [LEN_W-1:0] r_len;

    // first failing check wins
    always_comb begin
        priority if (i_sum.addr != r_slave_addr) begin
            n_verdict = VERDICT_BAD_ADDR;
        end else if (i_sum.func > LAST_LEGAL_FUNC) begin
            n_verdict = VERDICT_BAD_FUNC;
        end else if (i_sum.len < MIN_FRAME_BYTES) begin
            n_verdict = VERDICT_SHORT;
        end else if (!i_sum.crc_ok) begin
            n_verdict = VERDICT_BAD_CRC;
        end else begin
            n_verdict = VERDICT_OK;
        end
    end

    // refill the output register when it is free or being drained
    assign o_sum_take = i_sum_valid & (~r_valid | i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RESET;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_slave_addr <= i_cfg_wr_data;
            end
            if (o_sum_take) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sum_take) begin
            r_verdict <= n_verdict;
            r_func    <= i_sum.func;
            r_len     <= i_sum.len;
        end
    end

    assign o_empty         = ~r_valid;
    assign o_verdict       = r_verdict;
    assign o_function_code = r_func;
    assign o_frame_length  = r_len;

endmodule

### src/modbus_rtu_frame_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker_core
// Modbus RTU receive frame checker with CRC-16 and header checks.
// ----------------------------------------------------------------------------
// Input side is a queue write port: drive a byte and its end-of-frame flag,
// raise push; the word is taken on a clock edge where full is low. One byte
// is taken every cycle; full only rises when three verdicts are waiting (one
// in the output register, two queued) and the result side is stalled.
// Result side is a queue read port: while empty is low the oldest verdict,
// function code and frame length are on the outputs; pop takes it.
// Only the last byte of a frame yields a word: the edge that takes that
// byte pushes its summary into the summary queue, and it is graded into the
// output register once that register is free or being drained. Throughput
// is one byte per cycle while full is low, set by the front's unrolled CRC.
// A stalled reader backs up the output register and the two-entry summary
// queue; only then does full rise. Nothing is dropped.
// The slave address register is written on any edge with i_cfg_wr_en high;
// write it only while no frame is in flight.
// Reset (i_rst_n low, synchronous) clears frame state and the queue and
// sets the slave address to 1.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    input  logic       i_end_of_frame,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] o_verdict,
    output logic [7:0] o_function_code,
    output logic [mrfc_pkg::LEN_W-1:0] o_frame_length
);
    import mrfc_pkg::*;

    logic       accept;
    logic       sum_push;
    t_frame_sum sum_in, sum_out;
    logic       q_empty, q_full, sum_take;

    assign full   = q_full;
    assign accept = push & ~q_full;

    mrfc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (i_rx_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_sum_push     (sum_push),
        .o_sum          (sum_in)
    );

    mrfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sum_push),
        .i_data  (sum_in),
        .o_full  (q_full),
        .i_pop   (sum_take),
        .o_empty (q_empty),
        .o_data  (sum_out)
    );

    mrfc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_sum_valid     (~q_empty),
        .i_sum           (sum_out),
        .o_sum_take      (sum_take),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_verdict       (o_verdict),
        .o_function_code (o_function_code),
        .o_frame_length  (o_frame_length)
    );

endmodule
